// ===== hw/rtl/ple_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the list engine.
`timescale 1ns / 1ps
package ple_pkg;

  // Store geometry and capacity policy
  localparam int MAX_ENTRIES  = 64;
  localparam int MIN_CAPACITY = 11;
  localparam int ADDR_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);

  // Fixed field widths
  localparam int REQ_W    = 2;
  localparam int POS_W    = 6;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;

  localparam logic [CNT_W-1:0] MIN_CAP_C  = CNT_W'(MIN_CAPACITY);
  localparam logic [CNT_W-1:0] MAX_CNT_C  = CNT_W'(MAX_ENTRIES);
  localparam logic [CNT_W:0]   MAX_WIDE_C = (CNT_W + 1)'(MAX_ENTRIES);

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_DUMP   = 2'd3
  } ple_req_e;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOROOM = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic                load;      // capture the request beat
    logic                grow;      // double capacity when full
    logic                init_ptr;  // set the scan pointer for this request
    logic                issue;     // read at the scan pointer and step it
    logic                put_key;   // write the new key, bump the count
    logic                del_fin;   // drop the count, maybe halve capacity
    logic                emit;      // load a non-element result
    logic [STATUS_W-1:0] status;    // status for emit
  } ple_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    ple_req_e req;
    logic     bad_pos;
    logic     no_room;
    logic     no_shift;    // nothing to move (or nothing to dump)
    logic     last_issue;  // scan pointer sits on its final entry
  } ple_sts_t;

endpackage

// ===== hw/rtl/ple_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ple_ctrl.sv =====
// Request sequencer for the list engine: decides each step, drives the datapath.
`timescale 1ns / 1ps
module ple_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  ple_pkg::ple_sts_t sts_i,
  output ple_pkg::ple_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_ISSUE  = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_PUT    = 3'd4;
  localparam logic [2:0] S_DEL    = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.status = ple_pkg::ST_OK;
    state_d      = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        case (sts_i.req)
          ple_pkg::REQ_DUMP: begin
            if (sts_i.no_shift) begin
              cmd_o.emit = 1'b1;
              state_d    = S_IDLE;
            end else begin
              cmd_o.init_ptr = 1'b1;
              state_d        = S_ISSUE;
            end
          end
          ple_pkg::REQ_DELETE: begin
            if (sts_i.bad_pos) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = ple_pkg::ST_BADPOS;
              state_d      = S_IDLE;
            end else if (sts_i.no_shift) begin
              state_d = S_DEL;
            end else begin
              cmd_o.init_ptr = 1'b1;
              state_d        = S_ISSUE;
            end
          end
          default: begin
            // append and insert
            if (sts_i.bad_pos) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = ple_pkg::ST_BADPOS;
              state_d      = S_IDLE;
            end else if (sts_i.no_room) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = ple_pkg::ST_NOROOM;
              state_d      = S_IDLE;
            end else begin
              cmd_o.grow = 1'b1;
              if (sts_i.no_shift) begin
                state_d = S_PUT;
              end else begin
                cmd_o.init_ptr = 1'b1;
                state_d        = S_ISSUE;
              end
            end
          end
        endcase
      end
      S_ISSUE: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_issue) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last pending move or dump beat completes in the datapath
        case (sts_i.req)
          ple_pkg::REQ_DUMP:   state_d = S_IDLE;
          ple_pkg::REQ_DELETE: state_d = S_DEL;
          default:             state_d = S_PUT;
        endcase
      end
      S_PUT: begin
        cmd_o.put_key = 1'b1;
        state_d       = S_RESULT;
      end
      S_DEL: begin
        cmd_o.del_fin = 1'b1;
        state_d       = S_RESULT;
      end
      S_RESULT: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/ple_dp.sv =====
// List engine datapath: request capture, count/capacity, key store, scan and result registers.
`timescale 1ns / 1ps
module ple_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ple_pkg::ple_cmd_t                   cmd_i,
  output ple_pkg::ple_sts_t                   sts_o,
  input  logic [ple_pkg::REQ_W-1:0]           req_type_i,
  input  logic [ple_pkg::POS_W-1:0]           position_i,
  input  logic signed [ple_pkg::KEY_W-1:0]    key_i,
  output logic                                result_valid_o,
  output logic [ple_pkg::STATUS_W-1:0]        status_o,
  output logic [ple_pkg::CNT_W-1:0]           count_after_o,
  output logic [ple_pkg::CNT_W-1:0]           capacity_after_o,
  output logic signed [ple_pkg::KEY_W-1:0]    element_o,
  output logic                                element_valid_o,
  output logic                                last_o
);

  localparam int CW = ple_pkg::CNT_W;
  localparam int AW = ple_pkg::ADDR_W;
  localparam int KW = ple_pkg::KEY_W;

  ple_pkg::ple_req_e req_q;
  logic [CW-1:0]     pos_q;
  logic [KW-1:0]     key_q;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     cap_q, cap_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic              rd_pend_q;
  logic [AW-1:0]     rd_addr_q;

  logic                        out_valid_q, out_valid_d;
  logic [ple_pkg::STATUS_W-1:0] out_status_q;
  logic [CW-1:0]               out_count_q, out_cap_q;
  logic [KW-1:0]               out_elem_q;
  logic                        out_evalid_q, out_last_q;

  logic          is_ins;
  logic          is_dump;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] pos_p1;
  logic [CW:0]   cap_x2;
  logic [CW+1:0] three_cm1;
  logic [CW-1:0] ptr_ext;
  logic [CW-1:0] rd_addr_ext;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [KW-1:0] ram_wdata;
  logic [KW-1:0] ram_rdata;

  assign is_ins      = (req_q == ple_pkg::REQ_APPEND) || (req_q == ple_pkg::REQ_INSERT);
  assign is_dump     = (req_q == ple_pkg::REQ_DUMP);
  assign count_m1    = count_q - CW'(1);
  assign pos_p1      = pos_q + CW'(1);
  assign cap_x2      = {cap_q, 1'b0};
  assign three_cm1   = {1'b0, count_m1, 1'b0} + {2'b00, count_m1};
  assign ptr_ext     = CW'(ptr_q);
  assign rd_addr_ext = CW'(rd_addr_q);

  // Status toward the controller
  always_comb begin
    sts_o.req     = req_q;
    sts_o.no_room = ((count_q >= cap_q) && (cap_x2 > ple_pkg::MAX_WIDE_C)) ||
                    (count_q >= ple_pkg::MAX_CNT_C);
    if (req_q == ple_pkg::REQ_DELETE) begin
      sts_o.bad_pos = (pos_q >= count_q);
    end else begin
      sts_o.bad_pos = (pos_q > count_q);
    end
    case (req_q)
      ple_pkg::REQ_DELETE: sts_o.no_shift = (pos_p1 == count_q);
      ple_pkg::REQ_DUMP:   sts_o.no_shift = (count_q == '0);
      default:             sts_o.no_shift = (pos_q == count_q);
    endcase
    if (is_ins) begin
      sts_o.last_issue = (ptr_ext == pos_q);
    end else begin
      sts_o.last_issue = (ptr_ext == count_m1);
    end
  end

  // Scan pointer: insert walks down from the top, delete and dump walk up
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.init_ptr) begin
      case (req_q)
        ple_pkg::REQ_DELETE: ptr_d = pos_p1[AW-1:0];
        ple_pkg::REQ_DUMP:   ptr_d = '0;
        default:             ptr_d = count_m1[AW-1:0];
      endcase
    end else if (cmd_i.issue) begin
      ptr_d = is_ins ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
    end
  end

  // Count and capacity updates
  always_comb begin
    count_d = count_q;
    cap_d   = cap_q;
    if (cmd_i.grow && (count_q >= cap_q)) begin
      cap_d = cap_x2[CW-1:0];
    end
    if (cmd_i.put_key) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.del_fin) begin
      count_d = count_m1;
      if (({2'b00, cap_q} >= three_cm1) && ((cap_q >> 1) >= ple_pkg::MIN_CAP_C)) begin
        cap_d = cap_q >> 1;
      end
    end
  end

  // Store writes: moved entries once their read data returns, or the new key
  always_comb begin
    ram_we    = cmd_i.put_key || (rd_pend_q && !is_dump);
    ram_waddr = is_ins ? (rd_addr_q + AW'(1)) : (rd_addr_q - AW'(1));
    ram_wdata = ram_rdata;
    if (cmd_i.put_key) begin
      ram_waddr = pos_q[AW-1:0];
      ram_wdata = key_q;
    end
  end

  ple_ram #(
    .WIDTH (KW),
    .DEPTH (ple_pkg::MAX_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_d = cmd_i.emit || (rd_pend_q && is_dump);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= ple_pkg::MIN_CAP_C;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      req_q       <= ple_pkg::REQ_APPEND;
    end else begin
      count_q     <= count_d;
      cap_q       <= cap_d;
      rd_pend_q   <= cmd_i.issue;
      out_valid_q <= out_valid_d;
      if (cmd_i.load) begin
        req_q <= ple_pkg::ple_req_e'(req_type_i);
      end
    end
  end

  // Request payload, scan address and result payload
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.issue) begin
      rd_addr_q <= ptr_q;
    end
    if (cmd_i.load) begin
      key_q <= key_i;
      if (ple_pkg::ple_req_e'(req_type_i) == ple_pkg::REQ_APPEND) begin
        pos_q <= count_q;
      end else begin
        pos_q <= CW'(position_i);
      end
    end
    if (out_valid_d) begin
      out_count_q <= count_q;
      out_cap_q   <= cap_q;
      if (cmd_i.emit) begin
        out_status_q <= cmd_i.status;
        out_elem_q   <= '0;
        out_evalid_q <= 1'b0;
        out_last_q   <= 1'b1;
      end else begin
        out_status_q <= ple_pkg::ST_OK;
        out_elem_q   <= ram_rdata;
        out_evalid_q <= 1'b1;
        out_last_q   <= (rd_addr_ext == count_m1);
      end
    end
  end

  assign result_valid_o   = out_valid_q;
  assign status_o         = out_status_q;
  assign count_after_o    = out_count_q;
  assign capacity_after_o = out_cap_q;
  assign element_o        = out_elem_q;
  assign element_valid_o  = out_evalid_q;
  assign last_o           = out_last_q;

  // Checks
  a_cnt_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("element count above capacity");

  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q >= ple_pkg::MIN_CAP_C) && (cap_q <= ple_pkg::MAX_CNT_C))
    else $error("capacity out of range");

  a_wr_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.put_key |-> !rd_pend_q)
    else $error("key write collides with a pending move");

  a_put_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.put_key |=> (count_q == $past(count_q) + CW'(1)))
    else $error("count did not advance on key write");

endmodule

// ===== hw/rtl/positional_list_engine.sv =====
// Top level of the positional list engine: sequencer plus datapath.
//
// Usage: present req_type_i, position_i and key_i with start_i high; the beat
// is taken on a rising edge where start_i is high and busy_o is low. busy_o
// stays high until the request has finished. Results come out on
// result_valid_o, a one-cycle strobe per beat the receiver cannot hold off.
// Append, insert and delete give one result beat; a dump gives one beat per
// stored key (or one empty beat), last_o marking the final one.
// Rejected requests are answered straight from evaluation; a shifting insert or
// delete first moves each affected entry, then writes or drops; a dump gives
// its elements one per cycle once the scan starts. The single store read port
// moves or reads one entry per cycle. busy_o drops on the cycle the final
// result is shown, so the next request may be taken then.
// Reset clears the count to zero and the capacity to its minimum of eleven;
// the key store is not cleared, only written entries are ever read.
`timescale 1ns / 1ps
module positional_list_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [ple_pkg::REQ_W-1:0]           req_type_i,
  input  logic [ple_pkg::POS_W-1:0]           position_i,
  input  logic signed [ple_pkg::KEY_W-1:0]    key_i,
  output logic                                result_valid_o,
  output logic [ple_pkg::STATUS_W-1:0]        status_o,
  output logic [ple_pkg::CNT_W-1:0]           count_after_o,
  output logic [ple_pkg::CNT_W-1:0]           capacity_after_o,
  output logic signed [ple_pkg::KEY_W-1:0]    element_o,
  output logic                                element_valid_o,
  output logic                                last_o
);

  ple_pkg::ple_cmd_t cmd;
  ple_pkg::ple_sts_t sts;

  ple_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  ple_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_type_i       (req_type_i),
    .position_i       (position_i),
    .key_i            (key_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .count_after_o    (count_after_o),
    .capacity_after_o (capacity_after_o),
    .element_o        (element_o),
    .element_valid_o  (element_valid_o),
    .last_o           (last_o)
  );

endmodule

// ===== test/positional_list_engine_tb.sv =====
// Self-checking testbench for the positional list engine: directed table, then random phases.
`timescale 1ns / 1ps
module positional_list_engine_tb;

  localparam int RW          = ple_pkg::REQ_W;
  localparam int PW          = ple_pkg::POS_W;
  localparam int KW          = ple_pkg::KEY_W;
  localparam int SW          = ple_pkg::STATUS_W;
  localparam int CW          = ple_pkg::CNT_W;
  localparam int ITEMS       = 480;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = ple_pkg::MAX_ENTRIES + 16;
  localparam int PLAN_ROWS   = 23;

  localparam logic [CW-1:0] CAP_LO = ple_pkg::MIN_CAP_C;
  localparam logic [CW-1:0] CAP_HI = CW'(2 * ple_pkg::MIN_CAPACITY);

  // One result beat as seen on the ports
  typedef struct packed {
    logic [SW-1:0]        status;
    logic [CW-1:0]        count;
    logic [CW-1:0]        cap;
    logic signed [KW-1:0] elem;
    logic                 elem_valid;
    logic                 last;
  } beat_t;

  // One request; typed rows carry their expected single result
  typedef struct packed {
    ple_pkg::ple_req_e req;
    logic [PW-1:0]     pos;
    logic [KW-1:0]     key;
    logic              typed;
    logic [SW-1:0]     st;
    logic [CW-1:0]     cnt;
    logic [CW-1:0]     cap;
  } request_t;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} phase_e;

  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 start_i          = 1'b0;
  logic [RW-1:0]        req_type_i       = '0;
  logic [PW-1:0]        position_i       = '0;
  logic signed [KW-1:0] key_i            = '0;
  logic                 busy_o;
  logic                 result_valid_o;
  logic [SW-1:0]        status_o;
  logic [CW-1:0]        count_after_o;
  logic [CW-1:0]        capacity_after_o;
  logic signed [KW-1:0] element_o;
  logic                 element_valid_o;
  logic                 last_o;

  // Shadow copy of the list and expected result beats
  logic signed [KW-1:0] shadow_keys [ple_pkg::MAX_ENTRIES];
  int    shadow_count = 0;
  int    shadow_cap   = ple_pkg::MIN_CAPACITY;
  beat_t fresh_beats [$];
  beat_t awaited_beats [$];

  int  fail_count    = 0;
  int  beats_checked = 0;
  int  beats_sent    = 0;
  int  cycles        = 0;
  int  no_room_hits  = 0;
  int  grow_hits     = 0;
  int  shrink_hits   = 0;
  int  peak_count    = 0;
  bit  idle_on       = 1'b1;

  // Directed requests
  request_t plan [PLAN_ROWS] = '{
    '{ple_pkg::REQ_DUMP,   6'd0,  32'h0000_0000, 1'b1, ple_pkg::ST_OK,     7'd0,  CAP_LO},
    '{ple_pkg::REQ_DELETE, 6'd0,  32'h0000_0000, 1'b1, ple_pkg::ST_BADPOS, 7'd0,  CAP_LO},
    '{ple_pkg::REQ_INSERT, 6'd1,  32'h1234_5678, 1'b1, ple_pkg::ST_BADPOS, 7'd0,  CAP_LO},
    '{ple_pkg::REQ_APPEND, 6'd63, 32'h7FFF_FFFF, 1'b1, ple_pkg::ST_OK,     7'd1,  CAP_LO},
    '{ple_pkg::REQ_APPEND, 6'd0,  32'h8000_0000, 1'b1, ple_pkg::ST_OK,     7'd2,  CAP_LO},
    '{ple_pkg::REQ_INSERT, 6'd0,  32'hFFFF_FFFF, 1'b1, ple_pkg::ST_OK,     7'd3,  CAP_LO},
    '{ple_pkg::REQ_INSERT, 6'd63, 32'h0000_0000, 1'b1, ple_pkg::ST_BADPOS, 7'd3,  CAP_LO},
    '{ple_pkg::REQ_INSERT, 6'd3,  32'h0000_0000, 1'b1, ple_pkg::ST_OK,     7'd4,  CAP_LO},
    '{ple_pkg::REQ_DUMP,   6'd0,  32'h0000_0000, 1'b0, ple_pkg::ST_OK,     7'd0,  7'd0},
    '{ple_pkg::REQ_DELETE, 6'd63, 32'h0000_0000, 1'b1, ple_pkg::ST_BADPOS, 7'd4,  CAP_LO},
    '{ple_pkg::REQ_DELETE, 6'd4,  32'h0000_0000, 1'b1, ple_pkg::ST_BADPOS, 7'd4,  CAP_LO},
    '{ple_pkg::REQ_DELETE, 6'd1,  32'h0000_0000, 1'b1, ple_pkg::ST_OK,     7'd3,  CAP_LO},
    '{ple_pkg::REQ_APPEND, 6'd42, 32'h0000_0001, 1'b0, ple_pkg::ST_OK,     7'd0,  7'd0},
    '{ple_pkg::REQ_APPEND, 6'd21, 32'h5555_5555, 1'b0, ple_pkg::ST_OK,     7'd0,  7'd0},
    '{ple_pkg::REQ_APPEND, 6'd0,  32'hAAAA_AAAA, 1'b0, ple_pkg::ST_OK,     7'd0,  7'd0},
    '{ple_pkg::REQ_APPEND, 6'd7,  32'h0F0F_0F0F, 1'b0, ple_pkg::ST_OK,     7'd0,  7'd0},
    '{ple_pkg::REQ_APPEND, 6'd56, 32'hF0F0_F0F0, 1'b0, ple_pkg::ST_OK,     7'd0,  7'd0},
    '{ple_pkg::REQ_APPEND, 6'd1,  32'h0000_0002, 1'b0, ple_pkg::ST_OK,     7'd0,  7'd0},
    '{ple_pkg::REQ_APPEND, 6'd33, 32'hDEAD_BEEF, 1'b0, ple_pkg::ST_OK,     7'd0,  7'd0},
    '{ple_pkg::REQ_APPEND, 6'd12, 32'h3C3C_3C3C, 1'b0, ple_pkg::ST_OK,     7'd0,  7'd0},
    '{ple_pkg::REQ_INSERT, 6'd5,  32'hA5A5_A5A5, 1'b1, ple_pkg::ST_OK,     7'd12, CAP_HI},
    '{ple_pkg::REQ_DUMP,   6'd0,  32'h0000_0000, 1'b0, ple_pkg::ST_OK,     7'd0,  7'd0},
    '{ple_pkg::REQ_DELETE, 6'd0,  32'h0000_0000, 1'b1, ple_pkg::ST_OK,     7'd11, CAP_HI}
  };

  positional_list_engine DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .req_type_i       (req_type_i),
    .position_i       (position_i),
    .key_i            (key_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .count_after_o    (count_after_o),
    .capacity_after_o (capacity_after_o),
    .element_o        (element_o),
    .element_valid_o  (element_valid_o),
    .last_o           (last_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Build the result beat for a non-dump request
  function automatic beat_t status_beat(logic [SW-1:0] st);
    beat_t b;
    b.status     = st;
    b.count      = CW'(shadow_count);
    b.cap        = CW'(shadow_cap);
    b.elem       = '0;
    b.elem_valid = 1'b0;
    b.last       = 1'b1;
    return b;
  endfunction

  // Apply one request to the shadow list; result beats go to fresh_beats
  function automatic void list_update(request_t r);
    int            at;
    int            i;
    logic [SW-1:0] st;
    beat_t         b;
    fresh_beats.delete();
    st = ple_pkg::ST_OK;
    case (r.req)
      ple_pkg::REQ_APPEND, ple_pkg::REQ_INSERT: begin
        at = (r.req == ple_pkg::REQ_APPEND) ? shadow_count : int'(r.pos);
        if (at > shadow_count) begin
          st = ple_pkg::ST_BADPOS;
        end else if (shadow_count >= shadow_cap &&
                     2 * shadow_cap > ple_pkg::MAX_ENTRIES) begin
          st = ple_pkg::ST_NOROOM;
          no_room_hits++;
        end else begin
          if (shadow_count >= shadow_cap) begin
            shadow_cap = 2 * shadow_cap;
            grow_hits++;
          end
          if (shadow_count >= ple_pkg::MAX_ENTRIES) begin
            st = ple_pkg::ST_NOROOM;
          end else begin
            for (i = shadow_count; i > at; i--) shadow_keys[i] = shadow_keys[i-1];
            shadow_keys[at] = r.key;
            shadow_count++;
          end
        end
        fresh_beats.push_back(status_beat(st));
      end
      ple_pkg::REQ_DELETE: begin
        at = int'(r.pos);
        if (at >= shadow_count) begin
          st = ple_pkg::ST_BADPOS;
        end else begin
          for (i = at; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i+1];
          shadow_count--;
          if (shadow_cap >= 3 * shadow_count &&
              shadow_cap / 2 >= ple_pkg::MIN_CAPACITY) begin
            shadow_cap = shadow_cap / 2;
            shrink_hits++;
          end
        end
        fresh_beats.push_back(status_beat(st));
      end
      default: begin
        if (shadow_count == 0) begin
          fresh_beats.push_back(status_beat(ple_pkg::ST_OK));
        end else begin
          for (i = 0; i < shadow_count; i++) begin
            b            = status_beat(ple_pkg::ST_OK);
            b.elem       = shadow_keys[i];
            b.elem_valid = 1'b1;
            b.last       = (i + 1 == shadow_count);
            fresh_beats.push_back(b);
          end
        end
      end
    endcase
    if (shadow_count > peak_count) peak_count = shadow_count;
  endfunction

  // Offer one request until it is taken, idling start at random meanwhile
  task automatic send_request(request_t r);
    bit    taken;
    beat_t b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(99) < 7) begin
        start_i <= 1'b0;
      end else begin
        start_i    <= 1'b1;
        req_type_i <= r.req;
        position_i <= r.pos;
        key_i      <= r.key;
      end
      @(posedge clk_i);
      if (start_i && !busy_o) taken = 1'b1;
    end
    beats_sent++;
    list_update(r);
    if (r.typed) begin
      b            = '0;
      b.status     = r.st;
      b.count      = r.cnt;
      b.cap        = r.cap;
      b.last       = 1'b1;
      awaited_beats.push_back(b);
    end else begin
      foreach (fresh_beats[i]) awaited_beats.push_back(fresh_beats[i]);
    end
  endtask

  // Drop start and hold off until every awaited beat has arrived
  task automatic drain_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [KW-1:0] pick_key();
    case ($urandom_range(19))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Random request, mostly well-formed for the given phase
  function automatic request_t pick_request(phase_e ph);
    request_t r;
    int       roll;
    int       grow_pct;
    r       = '0;
    r.req   = ple_pkg::ple_req_e'($urandom_range(3));
    r.pos   = PW'($urandom_range(63));
    r.key   = pick_key();
    roll    = $urandom_range(99);
    if (roll < 8) return r;
    if (roll < 16) begin
      r.req = ple_pkg::REQ_DUMP;
      return r;
    end
    case (ph)
      PH_GROW:   grow_pct = 85;
      PH_SHRINK: grow_pct = 20;
      default:   grow_pct = 50;
    endcase
    if ($urandom_range(99) < grow_pct) begin
      r.req = ($urandom_range(1) == 0) ? ple_pkg::REQ_APPEND : ple_pkg::REQ_INSERT;
      if (r.req == ple_pkg::REQ_INSERT) r.pos = PW'($urandom_range(shadow_count));
    end else begin
      r.req = ple_pkg::REQ_DELETE;
      r.pos = (shadow_count > 0) ? PW'($urandom_range(shadow_count - 1)) : '0;
    end
    return r;
  endfunction

  // Result checker: every strobed beat against the oldest awaited one
  always @(posedge clk_i) begin : check_beats
    beat_t got;
    beat_t want;
    if (rst_ni && result_valid_o) begin
      got = '{status_o, count_after_o, capacity_after_o, element_o, element_valid_o, last_o};
      if (awaited_beats.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected beat status %0d count %0d cap %0d elem %h valid %b last %b",
                   $time, got.status, got.count, got.cap, got.elem, got.elem_valid, got.last);
      end else begin
        want = awaited_beats.pop_front();
        beats_checked++;
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: mismatch (exp/act) status %0d/%0d count %0d/%0d cap %0d/%0d",
                     $time, want.status, got.status, want.count, got.count,
                     want.cap, got.cap);
            $display("    elem %h/%h valid %b/%b last %b/%b",
                     want.elem, got.elem, want.elem_valid, got.elem_valid,
                     want.last, got.last);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus
  initial begin : stimulus
    int     phase_idx;
    int     len;
    int     j;
    phase_e ph;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (plan[i]) send_request(plan[i]);
    drain_results();

    // random phases, cycling grow / shrink / mixed
    phase_idx = 0;
    while (beats_sent < ITEMS) begin
      ph = phase_e'(phase_idx % 3);
      case (ph)
        PH_GROW:   len = $urandom_range(60, 90);
        PH_SHRINK: len = $urandom_range(50, 80);
        default:   len = $urandom_range(20, 50);
      endcase
      for (j = 0; j < len && beats_sent < ITEMS; j++) begin
        idle_on = !(beats_sent >= 200 && beats_sent < 300);
        send_request(pick_request(ph));
      end
      drain_results();
      phase_idx++;
    end

    // let any stray beat show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d result beats, peak list size %0d.",
             beats_sent, beats_checked, peak_count);
    $display("Capacity grew %0d times, shrank %0d times, refused growth %0d times.",
             grow_hits, shrink_hits, no_room_hits);
    if (fail_count == 0 && awaited_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
